/* rtl/core/bqo_pkg.sv */
// Shared widths and payload types for the box and quad overlap test pipeline.
package bqo_pkg;

  // Coordinate width of the quad corners and the box center.
  localparam int COORD_BITS = 24;
  // Width of the unsigned box half sizes.
  localparam int HALF_BITS = 20;

  // A box corner is the center plus or minus a half size, kept exact.
  localparam int PNT_BITS = ((COORD_BITS > HALF_BITS) ? COORD_BITS : (HALF_BITS + 1)) + 1;
  // A quad edge vector, or a quad corner minus the box center.
  localparam int EDGE_BITS = COORD_BITS + 1;
  // A test point minus a quad corner.
  localparam int DELTA_BITS = PNT_BITS + 1;
  // One term of a cross product.
  localparam int PROD_BITS = EDGE_BITS + DELTA_BITS;
  // A whole cross product.
  localparam int CROSS_BITS = PROD_BITS + 1;
  // Common width for comparing a distance against a half size.
  localparam int CMP_BITS = (EDGE_BITS > HALF_BITS) ? EDGE_BITS : HALF_BITS;

  // Number of register stages from the request port to the result port.
  localparam int NUM_STAGES = 5;
  // Points tested against the quad: the four box corners and the center.
  localparam int NUM_POINTS = 5;
  // Corners (and edges) of the quad.
  localparam int NUM_CORNERS = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [HALF_BITS-1:0]  half_t;
  typedef logic signed [PNT_BITS-1:0]   pnt_t;
  typedef logic signed [EDGE_BITS-1:0]  edge_t;
  typedef logic        [EDGE_BITS-1:0]  mag_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;
  typedef logic        [CMP_BITS-1:0]   cmp_t;

endpackage

/* rtl/core/box_quad_overlap_test.sv */
// Top level of the pipelined overlap test between a quadrilateral and an axis-aligned box.
//
// Each request carries four quad corners and a box given as a center and two half
// sizes, all in fixed point with 8 fraction bits. The block answers overlaps = 1 when
// any of the box's four corners or its center lies inside the quad, or when any quad
// corner lies inside the closed box. A point is inside the quad when, over the four
// directed edges corner i to corner i+1 (wrapping), no edge cross product is positive
// or none is negative, so a point on an edge line counts as inside. Only vertices are
// tested: a crossing made by edges alone is not reported. All arithmetic is exact.
// The block keeps no state between requests. It is a five-stage pipeline that takes
// one request per clock cycle while the result side does not stall. The stages are: box
// corners and quad edge vectors; point-to-corner offsets and absolute distances; the
// forty cross-product multiplies (twenty cross products, two terms each) next to the
// box containment compare; the cross-product subtract and sign; and the final
// reduction into the result register. Every stage holds a valid bit, and a stage
// loads whenever it is empty or the stage after it moves, so a stall on the result
// side only backs up into the request side once all five stages are full, and
// bubbles are squeezed out on the way.
module box_quad_overlap_test (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic signed [bqo_pkg::COORD_BITS-1:0] corner0_x,
  input  logic signed [bqo_pkg::COORD_BITS-1:0] corner0_y,
  input  logic signed [bqo_pkg::COORD_BITS-1:0] corner1_x,
  input  logic signed [bqo_pkg::COORD_BITS-1:0] corner1_y,
  input  logic signed [bqo_pkg::COORD_BITS-1:0] corner2_x,
  input  logic signed [bqo_pkg::COORD_BITS-1:0] corner2_y,
  input  logic signed [bqo_pkg::COORD_BITS-1:0] corner3_x,
  input  logic signed [bqo_pkg::COORD_BITS-1:0] corner3_y,
  input  logic signed [bqo_pkg::COORD_BITS-1:0] box_center_x,
  input  logic signed [bqo_pkg::COORD_BITS-1:0] box_center_y,
  input  logic        [bqo_pkg::HALF_BITS-1:0]  box_half_width,
  input  logic        [bqo_pkg::HALF_BITS-1:0]  box_half_height,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic                   overlaps
);

  // Pipeline control: one valid bit per stage and a load enable per stage.
  logic [bqo_pkg::NUM_STAGES-1:0] vld;
  logic [bqo_pkg::NUM_STAGES:0]   rdy;

  // Request corners gathered into arrays for the loops below.
  bqo_pkg::coord_t in_qx [bqo_pkg::NUM_CORNERS];
  bqo_pkg::coord_t in_qy [bqo_pkg::NUM_CORNERS];

  // Stage 1: test points, quad corners, edge vectors and corner offsets from the center.
  bqo_pkg::pnt_t   s1_px [bqo_pkg::NUM_POINTS];
  bqo_pkg::pnt_t   s1_py [bqo_pkg::NUM_POINTS];
  bqo_pkg::coord_t s1_qx [bqo_pkg::NUM_CORNERS];
  bqo_pkg::coord_t s1_qy [bqo_pkg::NUM_CORNERS];
  bqo_pkg::edge_t  s1_ex [bqo_pkg::NUM_CORNERS];
  bqo_pkg::edge_t  s1_ey [bqo_pkg::NUM_CORNERS];
  bqo_pkg::edge_t  s1_dx [bqo_pkg::NUM_CORNERS];
  bqo_pkg::edge_t  s1_dy [bqo_pkg::NUM_CORNERS];
  bqo_pkg::half_t  s1_hw;
  bqo_pkg::half_t  s1_hh;

  // Stage 2: offsets of every test point from every quad corner, and absolute distances.
  bqo_pkg::delta_t s2_dpx [bqo_pkg::NUM_POINTS][bqo_pkg::NUM_CORNERS];
  bqo_pkg::delta_t s2_dpy [bqo_pkg::NUM_POINTS][bqo_pkg::NUM_CORNERS];
  bqo_pkg::edge_t  s2_ex  [bqo_pkg::NUM_CORNERS];
  bqo_pkg::edge_t  s2_ey  [bqo_pkg::NUM_CORNERS];
  bqo_pkg::mag_t   s2_adx [bqo_pkg::NUM_CORNERS];
  bqo_pkg::mag_t   s2_ady [bqo_pkg::NUM_CORNERS];
  bqo_pkg::half_t  s2_hw;
  bqo_pkg::half_t  s2_hh;

  // Stage 3: the two terms of every cross product, and the box containment result.
  bqo_pkg::prod_t  s3_pa [bqo_pkg::NUM_POINTS][bqo_pkg::NUM_CORNERS];
  bqo_pkg::prod_t  s3_pb [bqo_pkg::NUM_POINTS][bqo_pkg::NUM_CORNERS];
  logic            s3_box_hit;
  logic            s3_box_hit_next;

  // Stage 4: sign of every cross product.
  logic [bqo_pkg::NUM_CORNERS-1:0] s4_pos [bqo_pkg::NUM_POINTS];
  logic [bqo_pkg::NUM_CORNERS-1:0] s4_neg [bqo_pkg::NUM_POINTS];
  logic                            s4_box_hit;

  // Stage 5 is the result register.
  logic overlap;
  logic overlap_next;

  // A stage loads when it is empty or its contents move on in the same cycle.
  always_comb begin
    rdy[bqo_pkg::NUM_STAGES] = !res_stall;
    for (int k = bqo_pkg::NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign req_stall = !rdy[0];
  assign res_valid = vld[bqo_pkg::NUM_STAGES-1];
  assign overlaps  = overlap;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < bqo_pkg::NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_qx[0] = corner0_x;
  assign in_qx[1] = corner1_x;
  assign in_qx[2] = corner2_x;
  assign in_qx[3] = corner3_x;
  assign in_qy[0] = corner0_y;
  assign in_qy[1] = corner1_y;
  assign in_qy[2] = corner2_y;
  assign in_qy[3] = corner3_y;

  // Stage 1: the box corners go counterclockwise from the low-low corner; the center is last.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_px[0] <= bqo_pkg::pnt_t'(box_center_x) - bqo_pkg::pnt_t'(box_half_width);
      s1_py[0] <= bqo_pkg::pnt_t'(box_center_y) - bqo_pkg::pnt_t'(box_half_height);
      s1_px[1] <= bqo_pkg::pnt_t'(box_center_x) + bqo_pkg::pnt_t'(box_half_width);
      s1_py[1] <= bqo_pkg::pnt_t'(box_center_y) - bqo_pkg::pnt_t'(box_half_height);
      s1_px[2] <= bqo_pkg::pnt_t'(box_center_x) + bqo_pkg::pnt_t'(box_half_width);
      s1_py[2] <= bqo_pkg::pnt_t'(box_center_y) + bqo_pkg::pnt_t'(box_half_height);
      s1_px[3] <= bqo_pkg::pnt_t'(box_center_x) - bqo_pkg::pnt_t'(box_half_width);
      s1_py[3] <= bqo_pkg::pnt_t'(box_center_y) + bqo_pkg::pnt_t'(box_half_height);
      s1_px[4] <= bqo_pkg::pnt_t'(box_center_x);
      s1_py[4] <= bqo_pkg::pnt_t'(box_center_y);
      for (int i = 0; i < bqo_pkg::NUM_CORNERS; i++) begin
        s1_qx[i] <= in_qx[i];
        s1_qy[i] <= in_qy[i];
        s1_ex[i] <= bqo_pkg::edge_t'(in_qx[(i + 1) % bqo_pkg::NUM_CORNERS])
                  - bqo_pkg::edge_t'(in_qx[i]);
        s1_ey[i] <= bqo_pkg::edge_t'(in_qy[(i + 1) % bqo_pkg::NUM_CORNERS])
                  - bqo_pkg::edge_t'(in_qy[i]);
        s1_dx[i] <= bqo_pkg::edge_t'(in_qx[i]) - bqo_pkg::edge_t'(box_center_x);
        s1_dy[i] <= bqo_pkg::edge_t'(in_qy[i]) - bqo_pkg::edge_t'(box_center_y);
      end
      s1_hw <= box_half_width;
      s1_hh <= box_half_height;
    end
  end

  // Stage 2: offsets for the cross products, and distances for the box test.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int p = 0; p < bqo_pkg::NUM_POINTS; p++) begin
        for (int i = 0; i < bqo_pkg::NUM_CORNERS; i++) begin
          s2_dpx[p][i] <= bqo_pkg::delta_t'(s1_px[p]) - bqo_pkg::delta_t'(s1_qx[i]);
          s2_dpy[p][i] <= bqo_pkg::delta_t'(s1_py[p]) - bqo_pkg::delta_t'(s1_qy[i]);
        end
      end
      for (int i = 0; i < bqo_pkg::NUM_CORNERS; i++) begin
        s2_ex[i]  <= s1_ex[i];
        s2_ey[i]  <= s1_ey[i];
        // The offsets never reach the most negative code, so the magnitude fits.
        s2_adx[i] <= s1_dx[i][bqo_pkg::EDGE_BITS-1] ? bqo_pkg::mag_t'(-s1_dx[i])
                                                    : bqo_pkg::mag_t'(s1_dx[i]);
        s2_ady[i] <= s1_dy[i][bqo_pkg::EDGE_BITS-1] ? bqo_pkg::mag_t'(-s1_dy[i])
                                                    : bqo_pkg::mag_t'(s1_dy[i]);
      end
      s2_hw <= s1_hw;
      s2_hh <= s1_hh;
    end
  end

  // A quad corner inside the closed box is a hit on its own.
  always_comb begin
    s3_box_hit_next = 1'b0;
    for (int i = 0; i < bqo_pkg::NUM_CORNERS; i++) begin
      if ((bqo_pkg::cmp_t'(s2_adx[i]) <= bqo_pkg::cmp_t'(s2_hw)) &&
          (bqo_pkg::cmp_t'(s2_ady[i]) <= bqo_pkg::cmp_t'(s2_hh))) begin
        s3_box_hit_next = 1'b1;
      end
    end
  end

  // Stage 3: multiplies, with the closed-box compare alongside.
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int p = 0; p < bqo_pkg::NUM_POINTS; p++) begin
        for (int i = 0; i < bqo_pkg::NUM_CORNERS; i++) begin
          s3_pa[p][i] <= bqo_pkg::prod_t'(s2_ex[i]) * bqo_pkg::prod_t'(s2_dpy[p][i]);
          s3_pb[p][i] <= bqo_pkg::prod_t'(s2_ey[i]) * bqo_pkg::prod_t'(s2_dpx[p][i]);
        end
      end
      s3_box_hit <= s3_box_hit_next;
    end
  end

  // Stage 4: subtract the two terms and keep only the sign.
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int p = 0; p < bqo_pkg::NUM_POINTS; p++) begin
        for (int i = 0; i < bqo_pkg::NUM_CORNERS; i++) begin
          s4_neg[p][i] <= (bqo_pkg::cross_t'(s3_pa[p][i])
                         - bqo_pkg::cross_t'(s3_pb[p][i])) < 0;
          s4_pos[p][i] <= (bqo_pkg::cross_t'(s3_pa[p][i])
                         - bqo_pkg::cross_t'(s3_pb[p][i])) > 0;
        end
      end
      s4_box_hit <= s3_box_hit;
    end
  end

  // A point is inside when its cross products never take both signs.
  always_comb begin
    overlap_next = s4_box_hit;
    for (int p = 0; p < bqo_pkg::NUM_POINTS; p++) begin
      if (!(|s4_pos[p]) || !(|s4_neg[p])) begin
        overlap_next = 1'b1;
      end
    end
  end

  // Stage 5: the result register.
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      overlap <= overlap_next;
    end
  end

endmodule
